### hdl/lifo_stack_with_peek_unit_defines.svh
// Assertion macros for the LIFO stack with peek.
// Included by the controller and the datapath; expects clk and rst_n in scope.
`ifndef LIFO_STACK_WITH_PEEK_UNIT_DEFINES_SVH
`define LIFO_STACK_WITH_PEEK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LSP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("stack assertion failed");
`define LSP_ASSERT_RST(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("stack reset assertion failed");
`else
`define LSP_ASSERT(label, prop)
`define LSP_ASSERT_RST(label, prop)
`endif

`endif

### hdl/lsp_pkg.sv
// Shared types and constants for the LIFO stack with peek.
// No dependencies; imported by every module of the block.
package lsp_pkg;

    localparam int DEF_DEPTH     = 256;
    localparam int DEF_WORD_BITS = 32;
    localparam int CAP_W         = 9;
    localparam int POS_W         = 9;
    localparam int VAL_W         = 32;
    localparam int CAP_RESET     = 256;

    localparam logic signed [VAL_W-1:0] ERR_VALUE = -32'sd1;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef struct packed {
        op_t                     operation;
        logic signed [VAL_W-1:0] push_value;
        logic [POS_W-1:0]        position;
    } req_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        status_t                 status;
        logic                    is_empty;
        logic                    is_full;
        logic [CAP_W-1:0]        occupancy;
    } resp_t;

    typedef enum logic {
        CS_IDLE = 1'b0,
        CS_READ = 1'b1
    } ctl_state_t;

    // exec: carry out the accepted request; load: move result to output register
    typedef struct packed {
        logic exec;
        logic load;
    } cmd_t;

endpackage

### hdl/lsp_ctrl.sv
// Handshake controller for the LIFO stack with peek.
// Depends on lsp_pkg and the assertion macro header.
`include "lifo_stack_with_peek_unit_defines.svh"

module lsp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          resp_valid,
    input  logic          resp_stall,
    output lsp_pkg::cmd_t cmd
);
    import lsp_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !resp_stall;

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        cmd        = '0;
        case (state_reg)
            CS_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.exec   = 1'b1;
                    state_next = CS_READ;
                end
            end
            CS_READ:
            begin
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
        out_valid_next = cmd.load ? 1'b1 : (out_valid_reg && resp_stall);
    end

    assign resp_valid = out_valid_reg;

    `LSP_ASSERT(a_exec_to_read, cmd.exec |=> state_reg == CS_READ)
    `LSP_ASSERT(a_no_overwrite, cmd.load |-> (!out_valid_reg || !resp_stall))
    `LSP_ASSERT(a_valid_from_read, $rose(out_valid_reg) |-> $past(state_reg) == CS_READ)
    `LSP_ASSERT_RST(a_reset_clear, !rst_n |=> !out_valid_reg)

endmodule

### hdl/lsp_datapath.sv
// Stack RAM, occupancy counter, capacity register and result register.
// Depends on lsp_pkg and the assertion macro header.
`include "lifo_stack_with_peek_unit_defines.svh"

module lsp_datapath #(
    parameter int DEPTH     = lsp_pkg::DEF_DEPTH,
    parameter int WORD_BITS = lsp_pkg::DEF_WORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lsp_pkg::cmd_t             cmd,
    input  lsp_pkg::req_t             req,
    input  logic                      cfg_we,
    input  logic [lsp_pkg::CAP_W-1:0] cfg_data,
    output lsp_pkg::resp_t            resp
);
    import lsp_pkg::*;

    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_INIT  = (DEPTH < CAP_RESET) ? DEPTH : CAP_RESET;

    logic [WORD_BITS-1:0]        mem [DEPTH];
    logic signed [WORD_BITS-1:0] rd_word_reg;
    logic signed [WORD_BITS-1:0] wr_word;

    logic [CMP_W-1:0]  cap_eff_reg;
    logic [CMP_W-1:0]  cap_eff_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    status_t           st_reg;
    status_t           st_next;
    logic              use_rd_reg;
    logic              use_rd_next;
    resp_t             resp_reg;
    resp_t             resp_next;

    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  pos_x;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic              mem_re;

    assign cnt_x   = CMP_W'(count_reg);
    assign pos_x   = CMP_W'(req.position);
    assign wr_word = WORD_BITS'(req.push_value);

    // capacity is clamped to 1..DEPTH at write time
    always_comb
    begin
        if (cfg_data == '0)
            cap_eff_next = CMP_W'(1);
        else if (CMP_W'(cfg_data) > CMP_W'(DEPTH))
            cap_eff_next = CMP_W'(DEPTH);
        else
            cap_eff_next = CMP_W'(cfg_data);
    end

    always_comb
    begin
        st_next     = ST_OK;
        use_rd_next = 1'b0;
        count_next  = count_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = count_reg[ADDR_W-1:0];
        case (req.operation)
            OP_PUSH:
            begin
                if (cnt_x >= cap_eff_reg)
                    st_next = ST_OVERFLOW;
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (count_reg == '0)
                    st_next = ST_UNDERFLOW;
                else
                begin
                    mem_re      = 1'b1;
                    use_rd_next = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                    mem_addr    = ADDR_W'(count_reg - CNT_W'(1));
                end
            end
            OP_PEEK:
            begin
                if (pos_x == '0 || pos_x > cnt_x)
                    st_next = ST_INVALID;
                else
                begin
                    mem_re      = 1'b1;
                    use_rd_next = 1'b1;
                    mem_addr    = ADDR_W'(cnt_x - pos_x);
                end
            end
            default:
            begin
                st_next = ST_INVALID;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_eff_reg <= CMP_W'(CAP_INIT);
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_eff_reg <= cap_eff_next;
            if (cmd.exec)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            if (mem_we)
                mem[mem_addr] <= wr_word;
            if (mem_re)
                rd_word_reg <= mem[mem_addr];
            st_reg     <= st_next;
            use_rd_reg <= use_rd_next;
        end
        if (cmd.load)
            resp_reg <= resp_next;
    end

    // count_reg already holds the post-step occupancy here
    always_comb
    begin
        resp_next.read_value = use_rd_reg ? VAL_W'(rd_word_reg) : ERR_VALUE;
        resp_next.status     = st_reg;
        resp_next.is_empty   = (count_reg == '0);
        resp_next.is_full    = (cnt_x >= cap_eff_reg);
        resp_next.occupancy  = CAP_W'(count_reg);
    end

    assign resp = resp_reg;

    `LSP_ASSERT(a_count_bound, cnt_x <= CMP_W'(DEPTH))
    `LSP_ASSERT(a_count_hold, !cmd.exec |=> $stable(count_reg))
    `LSP_ASSERT(a_pop_dec, cmd.exec && req.operation == OP_POP && count_reg != '0 |=> count_reg == $past(count_reg) - CNT_W'(1))

endmodule

### hdl/lifo_stack_with_peek_unit.sv
// channel   signals                        word
// request   req_valid / req_stall / req    operation, push_value, position
// response  resp_valid / resp_stall / resp read_value, status, flags, occupancy
// config    cfg_valid / cfg_ready          cfg_data: capacity (always ready)
//
// One request at a time: accept, then the read state for the registered read
// of the single-port stack RAM. The result sits in an output register, so the
// next request is taken while it waits. Reset empties the stack and sets the
// capacity to 256 (clamped to DEPTH); RAM contents are not cleared. A stalled
// response holds the block in its read state until the output register frees.
//
// Top level of the LIFO stack with peek; depends on lsp_pkg, lsp_ctrl and
// lsp_datapath.
module lifo_stack_with_peek_unit #(
    parameter int DEPTH     = lsp_pkg::DEF_DEPTH,
    parameter int WORD_BITS = lsp_pkg::DEF_WORD_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  lsp_pkg::req_t             req,
    output logic                      resp_valid,
    input  logic                      resp_stall,
    output lsp_pkg::resp_t            resp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [lsp_pkg::CAP_W-1:0] cfg_data
);
    import lsp_pkg::*;

    cmd_t cmd;

    assign cfg_ready = 1'b1;

    lsp_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .cmd        (cmd)
    );

    lsp_datapath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .resp     (resp)
    );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench for lifo_stack_with_peek_unit: push/pop/peek words checked against a
// behavioral stack predictor. Depends on lsp_pkg and the block's RTL.
module tb_top;
    import lsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLD_CYCLES    = 80;
    localparam op_t OP_UNUSED     = op_t'(2'd3);

    // predicted stack contents and occupancy, plus the queue of awaited results
    class stack_predictor;
        logic signed [VAL_W-1:0] words [DEF_DEPTH];
        int unsigned             depth_used;
        logic [CAP_W-1:0]        capacity;
        resp_t                   awaited[$];
        int                      errors;

        function new();
            depth_used = 0;
            capacity   = CAP_W'(CAP_RESET);
            errors     = 0;
        endfunction

        function int unsigned cap_in_use();
            if (capacity == 0)
                return 1;
            if (capacity > DEF_DEPTH)
                return DEF_DEPTH;
            return capacity;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] v);
            capacity = v;
        endfunction

        function void note_request(req_t r);
            resp_t       exp;
            int unsigned lim;
            lim            = cap_in_use();
            exp.read_value = ERR_VALUE;
            exp.status     = ST_OK;
            case (r.operation)
                OP_PUSH:
                begin
                    if (depth_used >= lim)
                        exp.status = ST_OVERFLOW;
                    else
                    begin
                        words[depth_used] = r.push_value;
                        depth_used++;
                    end
                end
                OP_POP:
                begin
                    if (depth_used == 0)
                        exp.status = ST_UNDERFLOW;
                    else
                    begin
                        depth_used--;
                        exp.read_value = words[depth_used];
                    end
                end
                OP_PEEK:
                begin
                    if (r.position == 0 || r.position > depth_used)
                        exp.status = ST_INVALID;
                    else
                        exp.read_value = words[depth_used - r.position];
                end
                default:
                    exp.status = ST_INVALID;
            endcase
            exp.is_empty  = (depth_used == 0);
            exp.is_full   = (depth_used >= lim);
            exp.occupancy = CAP_W'(depth_used);
            awaited.push_back(exp);
        endfunction

        function void compare_field(string name, longint exp_v, longint got_v);
            if (exp_v != got_v)
            begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(resp_t got);
            resp_t exp;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected word: got value %0d status %0d occupancy %0d",
                         $time, got.read_value, got.status, got.occupancy);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            compare_field("read_value", exp.read_value, got.read_value);
            compare_field("status", exp.status, got.status);
            compare_field("is_empty", exp.is_empty, got.is_empty);
            compare_field("is_full", exp.is_full, got.is_full);
            compare_field("occupancy", exp.occupancy, got.occupancy);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    req_t             req;
    logic             resp_valid;
    logic             resp_stall;
    resp_t            resp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data;

    stack_predictor pred;
    int             send_idle_pct;
    int             stall_pct;
    logic           hold_stall;
    int             quiet_cycles;

    // random phases: capacity, item count, push and pop share in percent
    int phase_cap  [8] = '{256, 100, 0, 511, 4, 1, 17, 256};
    int phase_len  [8] = '{300, 80, 40, 60, 80, 40, 100, 150};
    int phase_push [8] = '{92, 40, 45, 50, 45, 50, 50, 10};
    int phase_pop  [8] = '{4, 50, 45, 40, 45, 40, 40, 80};

    lifo_stack_with_peek_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .resp       (resp),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        resp_stall <= hold_stall || ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (resp_valid && !resp_stall)
                pred.check_result(resp);
            if (req_valid && !req_stall)
                pred.note_request(req);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (resp_valid && !resp_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // the request and config driving tasks start and end just after a falling edge
    task automatic send_item(req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic send_fields(op_t op, logic signed [VAL_W-1:0] v, logic [POS_W-1:0] p);
        req_t r;
        r.operation  = op;
        r.push_value = v;
        r.position   = p;
        send_item(r);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pred.awaited.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        pred.set_capacity(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic hold_receiver(int cycles);
        hold_stall = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_stall = 1'b0;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1:
            begin
                send_idle_pct = 74;
                stall_pct     = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct     = 74;
            end
            default:
            begin
                send_idle_pct = 25;
                stall_pct     = 25;
            end
        endcase
    endtask

    function automatic req_t make_item(int push_pct, int pop_pct);
        req_t        r;
        int          pick;
        int unsigned held;
        held         = pred.depth_used;
        r.push_value = $urandom;
        r.position   = POS_W'($urandom_range(0, DEF_DEPTH));
        pick         = $urandom_range(99);
        if (pick < push_pct)
        begin
            r.operation = OP_PUSH;
            case ($urandom_range(19))
                0: r.push_value = 32'sh7fffffff;
                1: r.push_value = 32'sh80000000;
                2: r.push_value = '0;
                3: r.push_value = ERR_VALUE;
                default: ;
            endcase
        end
        else if (pick < push_pct + pop_pct)
            r.operation = OP_POP;
        else if (pick < 98)
        begin
            r.operation = OP_PEEK;
            pick        = $urandom_range(99);
            if (pick < 70 && held > 0)
                r.position = POS_W'($urandom_range(1, held));
            else if (pick < 80)
                r.position = '0;
            else if (pick < 90)
                r.position = POS_W'((held < DEF_DEPTH) ? held + 1 : DEF_DEPTH);
        end
        else
            r.operation = OP_UNUSED;
        return r;
    endfunction

    initial
    begin
        pred          = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        hold_stall    = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty stack, signed extremes, peek bounds, unused opcode
        send_fields(OP_POP, 32'sd5, 9'd0);
        send_fields(OP_PEEK, 32'sd0, 9'd1);
        send_fields(OP_PUSH, 32'sh7fffffff, 9'd0);
        send_fields(OP_PUSH, 32'sh80000000, 9'd256);
        send_fields(OP_PUSH, ERR_VALUE, 9'd0);
        send_fields(OP_PUSH, 32'sd0, 9'd0);
        send_fields(OP_PEEK, 32'sd0, 9'd0);
        send_fields(OP_PEEK, 32'sd0, 9'd1);
        send_fields(OP_PEEK, 32'sd0, 9'd4);
        send_fields(OP_PEEK, 32'sd0, 9'd5);
        send_fields(OP_PEEK, 32'sd0, 9'd256);
        send_fields(OP_UNUSED, 32'sd9, 9'd1);
        repeat (5) send_fields(OP_POP, 32'sd0, 9'd0);

        // capacity dropped below the held count: full, pushes refused, reads still work
        wait_drained();
        write_capacity(9'd3);
        send_fields(OP_PUSH, 32'sd11, 9'd0);
        send_fields(OP_PUSH, -32'sd22, 9'd0);
        send_fields(OP_PUSH, 32'sd33, 9'd0);
        send_fields(OP_PUSH, 32'sd44, 9'd0);
        wait_drained();
        write_capacity(9'd1);
        send_fields(OP_PUSH, 32'sd55, 9'd0);
        send_fields(OP_PEEK, 32'sd0, 9'd3);
        repeat (3) send_fields(OP_POP, 32'sd0, 9'd0);

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            write_capacity(CAP_W'(phase_cap[ph]));
            set_idling(ph % 4);
            if (ph == 0)
            begin
                // long receiver hold while words keep coming: block backs up
                fork
                    hold_receiver(HOLD_CYCLES);
                join_none
            end
            for (int i = 0; i < phase_len[ph]; i++)
            begin
                if (ph == 4 && i == phase_len[ph] / 2)
                    wait_drained();
                send_item(make_item(phase_push[ph], phase_pop[ph]));
            end
        end

        wait_drained();
        if (pred.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
